[sv/sat_pkg.sv]
// Shared types, sizes and codes for the sorted array table.
// No dependencies; imported by every module of the block.
package sat_pkg;

    localparam int CAPACITY      = 32;
    localparam int KEY_BITS      = 16;
    localparam int PAYLOAD_BITS  = 32;
    localparam int IDX_W         = $clog2(CAPACITY);
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int ENTRY_COUNT_W = 6;
    localparam int IN_TDATA_W    = 56;
    localparam int OUT_TDATA_W   = 48;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

    typedef struct packed {
        logic [1:0]              status;
        logic [PAYLOAD_BITS-1:0] found_payload;
        logic [CNT_W-1:0]        count;
    } t_result;

endpackage

[sv/sat_mem.sv]
// Entry store: one write port, one read port with registered read data.
// Depends on sat_pkg.
module sat_mem (
    input  logic              i_clk,
    input  sat_pkg::t_mem_req i_req,
    output sat_pkg::t_entry   o_rdata
);
    import sat_pkg::*;

    t_entry r_mem [CAPACITY];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/sat_ctrl.sv]
// Sequencer: walks the store one entry per cycle to search, then shifts
// entries up or down for insert and remove. Depends on sat_pkg.
module sat_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [1:0]                     i_op,
    input  logic [sat_pkg::KEY_BITS-1:0]   i_key,
    input  logic [sat_pkg::PAYLOAD_BITS-1:0] i_payload,
    output sat_pkg::t_mem_req              o_mem_req,
    input  sat_pkg::t_entry                i_rdata,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output sat_pkg::t_result               o_res
);
    import sat_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SRCH = 2'd1;
    localparam logic [1:0] S_SHFT = 2'd2;
    localparam logic [1:0] S_RES  = 2'd3;

    logic [1:0]              r_state, n_state;
    logic [1:0]              r_op, n_op;
    logic [KEY_BITS-1:0]     r_key, n_key;
    logic [PAYLOAD_BITS-1:0] r_pay, n_pay;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CNT_W-1:0]        r_src, n_src;
    logic [CNT_W-1:0]        r_pidx, n_pidx;
    logic [CNT_W-1:0]        r_pos, n_pos;
    logic                    r_pv, n_pv;
    logic                    r_iss, n_iss;
    logic [1:0]              r_status, n_status;
    logic [PAYLOAD_BITS-1:0] r_found, n_found;

    logic             lt, eq, last, up;
    logic [CNT_W-1:0] pidx_inc, pidx_dec, pos;

    assign lt       = i_rdata.key < r_key;
    assign eq       = i_rdata.key == r_key;
    assign pidx_inc = r_pidx + CNT_W'(1);
    assign pidx_dec = r_pidx - CNT_W'(1);
    assign last     = pidx_inc == r_count;
    assign up       = r_op == OP_INSERT;
    assign pos      = lt ? r_count : r_pidx;

    assign o_ready     = r_state == S_IDLE;
    assign o_res_valid = r_state == S_RES;
    assign o_res       = '{status: r_status, found_payload: r_found, count: r_count};

    always_comb begin
        o_mem_req.raddr = r_src[IDX_W-1:0];
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = IDX_W'(r_pos);
        o_mem_req.wdata = '{key: r_key, payload: r_pay};
        if (r_state == S_SHFT) begin
            if (r_pv) begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = up ? IDX_W'(pidx_inc) : IDX_W'(pidx_dec);
                o_mem_req.wdata = i_rdata;
            end else if (!r_iss && up) begin
                o_mem_req.we = 1'b1;
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_op     = r_op;
        n_key    = r_key;
        n_pay    = r_pay;
        n_count  = r_count;
        n_src    = r_src;
        n_pidx   = r_pidx;
        n_pos    = r_pos;
        n_pv     = r_pv;
        n_iss    = r_iss;
        n_status = r_status;
        n_found  = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op     = i_op;
                    n_key    = i_key;
                    n_pay    = i_payload;
                    n_pv     = 1'b0;
                    n_iss    = 1'b0;
                    n_src    = '0;
                    n_pos    = '0;
                    n_found  = '0;
                    n_status = ST_OK;
                    unique case (i_op) inside
                        OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_RES;
                        end
                        OP_INSERT: begin
                            if (r_count == CNT_W'(CAPACITY)) begin
                                n_status = ST_FULL;
                                n_state  = S_RES;
                            end else if (r_count == '0) begin
                                n_state = S_SHFT;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        OP_LOOKUP, OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_status = ST_MISSING;
                                n_state  = S_RES;
                            end else begin
                                n_state = S_SRCH;
                            end
                        end
                        default: n_state = S_RES;
                    endcase
                end
            end
            S_SRCH: begin
                n_src  = r_src + CNT_W'(1);
                n_pv   = 1'b1;
                n_pidx = r_src;
                if (r_pv && (!lt || last)) begin
                    n_pv = 1'b0;
                    case (r_op)
                        OP_LOOKUP: begin
                            if (eq) begin
                                n_found = i_rdata.payload;
                            end else begin
                                n_status = ST_MISSING;
                            end
                            n_state = S_RES;
                        end
                        OP_REMOVE: begin
                            if (eq) begin
                                n_pos   = r_pidx;
                                n_src   = pidx_inc;
                                n_iss   = pidx_inc < r_count;
                                n_state = S_SHFT;
                            end else begin
                                n_status = ST_MISSING;
                                n_state  = S_RES;
                            end
                        end
                        OP_INSERT: begin
                            if (eq) begin
                                n_status = ST_DUP;
                                n_state  = S_RES;
                            end else begin
                                n_pos   = pos;
                                n_src   = r_count - CNT_W'(1);
                                n_iss   = r_count > pos;
                                n_state = S_SHFT;
                            end
                        end
                        default: n_state = S_RES;
                    endcase
                end
            end
            S_SHFT: begin
                if (r_iss) begin
                    n_pv   = 1'b1;
                    n_pidx = r_src;
                    if (up) begin
                        if (r_src == r_pos) n_iss = 1'b0;
                        else                n_src = r_src - CNT_W'(1);
                    end else begin
                        if (r_src == r_count - CNT_W'(1)) n_iss = 1'b0;
                        else                             n_src = r_src + CNT_W'(1);
                    end
                end else begin
                    n_pv = 1'b0;
                end
                if (!r_iss && !r_pv) begin
                    n_count = up ? r_count + CNT_W'(1) : r_count - CNT_W'(1);
                    n_state = S_RES;
                end
            end
            S_RES: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pv    <= 1'b0;
            r_iss   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pv    <= n_pv;
            r_iss   <= n_iss;
        end
        r_op     <= n_op;
        r_key    <= n_key;
        r_pay    <= n_pay;
        r_src    <= n_src;
        r_pidx   <= n_pidx;
        r_pos    <= n_pos;
        r_status <= n_status;
        r_found  <= n_found;
    end

endmodule

[sv/sorted_array_table_top.sv]
// Top level of the sorted array table: stream ports, sequencer, entry
// store and output register. Depends on sat_pkg, sat_mem, sat_ctrl.
//
//  Channel  | Dir | Fields (tdata, lowest bit up)
//  s_axis   | in  | op[1:0] key[17:2] payload[49:18], zero pad to 56
//  m_axis   | out | status[1:0] found_payload[33:2] entry_count[39:34]
//           |     | is_empty[40] is_full[41], zero pad to 48
//
// One beat at a time. Lookup, remove and insert into a non-empty table
// search the entries in order through the single read port of the entry
// store, one entry per cycle; insert and remove then shift them. Clear,
// insert into a full table and lookup or remove on an empty table skip both.
// Reset clears the count, not the store; the store needs no clearing pass.
// A stalled result waits in the output register; a following result waits
// in the sequencer, which then takes no new beat.
module sorted_array_table_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // op, key, payload
    input  logic [sat_pkg::IN_TDATA_W-1:0] i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // status, found_payload, entry_count, is_empty, is_full
    output logic [sat_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import sat_pkg::*;

    localparam int OUT_USED_W = 2 + PAYLOAD_BITS + ENTRY_COUNT_W + 2;

    t_mem_req mem_req;
    t_entry   rdata;
    t_result  res;
    logic     res_valid, res_ready;

    logic    r_ovalid;
    t_result r_ores;

    logic [ENTRY_COUNT_W-1:0] entry_count;
    logic                     is_empty, is_full;

    sat_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

    sat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_op        (i_s_axis_tdata[1:0]),
        .i_key       (i_s_axis_tdata[2 +: KEY_BITS]),
        .i_payload   (i_s_axis_tdata[2 + KEY_BITS +: PAYLOAD_BITS]),
        .o_mem_req   (mem_req),
        .i_rdata     (rdata),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    assign res_ready = !r_ovalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res_ready) begin
            r_ovalid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_ores <= res;
        end
    end

    assign entry_count = ENTRY_COUNT_W'(r_ores.count);
    assign is_empty    = r_ores.count == '0;
    assign is_full     = r_ores.count == CNT_W'(CAPACITY);

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, is_full, is_empty,
                              entry_count, r_ores.found_payload, r_ores.status};

endmodule

[sv/sat_chk.sv]
// Port-level checks for sorted_array_table_top, bound to the top level.
// Depends on sat_pkg and sorted_array_table_top.
module sat_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [sat_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [sat_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata
);
    import sat_pkg::*;

    logic [1:0] out_status;
    logic [5:0] out_count;

    assign out_status = o_m_axis_tdata[1:0];
    assign out_count  = o_m_axis_tdata[39:34];

    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat right after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second beat taken while one is at work");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[40] == (out_count == 6'd0))
        else $error("empty flag disagrees with count");

    a_full_refusal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && out_status == ST_FULL |-> o_m_axis_tdata[41])
        else $error("full refusal while table not full");

endmodule

bind sorted_array_table_top sat_chk u_sat_chk (.*);
